/* sv/mdh_pkg.sv */
// shared types, constants and helper functions of the manhattan distance heat map
// no dependencies
package mdh_pkg;

  localparam int MAX_ROWS = 128;
  localparam int MAX_COLS = 128;
  localparam int CELLS    = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int DIST_W   = $clog2(MAX_ROWS + MAX_COLS) + 1;
  localparam int DIM_W    = 9;
  localparam int HEAT_W   = 9;
  localparam int HEAT_CAP = 255;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [DIST_W-1:0] dist_t;
  typedef logic signed [HEAT_W-1:0] heat_t;

  localparam dist_t FAR_AWAY = '1;
  localparam heat_t HEAT_OWN = -9'sd1;
  localparam heat_t HEAT_OPP = -9'sd2;
  localparam heat_t HEAT_NONE = -9'sd1;

  localparam logic [1:0] CODE_EMPTY = 2'd0;
  localparam logic [1:0] CODE_OWN   = 2'd1;
  localparam logic [1:0] CODE_OPP   = 2'd2;
  localparam logic [1:0] CODE_BAD   = 2'd3;

  localparam logic [1:0] CFG_GRID_ROWS   = 2'd0;
  localparam logic [1:0] CFG_GRID_COLS   = 2'd1;
  localparam logic [1:0] CFG_TARGET_CODE = 2'd2;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_BUILD = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NB    = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LATCH,
    DP_LOAD,
    DP_RD_USE,
    DP_NB_START,
    DP_NB_ISSUE,
    DP_NB_USE,
    DP_FW_START,
    DP_FW_ISSUE,
    DP_FW_USE,
    DP_BW_USE,
    DP_RESP
  } dp_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_LOAD,
    ST_RD_ISSUE,
    ST_RD_USE,
    ST_NB_ISSUE,
    ST_NB_USE,
    ST_FW_ISSUE,
    ST_FW_USE,
    ST_BW_ISSUE,
    ST_BW_USE,
    ST_RESP
  } state_t;

  typedef struct packed {
    req_t req;
    logic in_grid;
    logic fw_last;
    logic bw_last;
    logic nb_last;
    logic out_free;
  } dp_status_t;

  function automatic addr_t cell_idx(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    cell_idx = ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c));
  endfunction

  function automatic dist_t min_plus_one(dist_t cur, dist_t nb);
    if (nb != FAR_AWAY && (nb + dist_t'(1)) < cur) begin
      min_plus_one = nb + dist_t'(1);
    end else begin
      min_plus_one = cur;
    end
  endfunction

endpackage

/* sv/mdh_in_if.sv */
// request channel: valid/ready handshake with the request fields
// no dependencies
interface mdh_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [6:0] row;
  logic [6:0] col;
  logic [1:0] cell_code;

  modport source (output valid, req_type, row, col, cell_code, input ready);
  modport sink (input valid, req_type, row, col, cell_code, output ready);
endinterface

/* sv/mdh_out_if.sv */
// result channel: valid/ready handshake with value and status
// no dependencies
interface mdh_out_if;
  logic              valid;
  logic              ready;
  logic signed [8:0] value;
  logic              status;

  modport source (output valid, value, status, input ready);
  modport sink (input valid, value, status, output ready);
endinterface

/* sv/mdh_datapath.sv */
// datapath: config registers, cell/work/heat memories, counters, result register
// depends on mdh_pkg
module mdh_datapath
  import mdh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic [1:0]        in_req_type,
  input  logic [6:0]        in_row,
  input  logic [6:0]        in_col,
  input  logic [1:0]        in_cell_code,
  input  dp_cmd_t           cmd,
  output dp_status_t        status,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [8:0] out_value,
  output logic              out_status
);

  logic [7:0] grid_rows_r, grid_cols_r;
  logic [1:0] target_code_r;
  logic [DIM_W-1:0] nr, nc;

  req_t       req_r;
  logic [6:0] row_r, col_r;
  logic [1:0] code_r;
  logic       in_grid_r;

  logic [ROW_W-1:0] r_r;
  logic [COL_W-1:0] c_r;
  logic [1:0]       dr_r, dc_r;
  logic             nb_ok_r;
  logic             any_r;
  dist_t            link_r;
  heat_t            res_r;

  logic  out_valid_r, out_status_r;
  heat_t out_value_r;

  logic [1:0] code_mem [CELLS];
  dist_t      work_mem [CELLS];
  heat_t      heat_mem [CELLS];
  logic [1:0] code_q;
  dist_t      work_a_q, work_b_q;
  heat_t      heat_q;

  addr_t cur_idx, up_idx, down_idx, req_idx, nb_idx, work_a_addr, heat_addr;
  logic [7:0] nb_rr, nb_cc;
  logic       nb_ok, last_row, last_col, hit;
  dist_t      d0, d1, fw_d, b1, bw_d;
  heat_t      heat_new;

  always_comb begin
    if (grid_rows_r == 8'd0) begin
      nr = DIM_W'(1);
    end else if ({1'b0, grid_rows_r} > DIM_W'(MAX_ROWS)) begin
      nr = DIM_W'(MAX_ROWS);
    end else begin
      nr = {1'b0, grid_rows_r};
    end
    if (grid_cols_r == 8'd0) begin
      nc = DIM_W'(1);
    end else if ({1'b0, grid_cols_r} > DIM_W'(MAX_COLS)) begin
      nc = DIM_W'(MAX_COLS);
    end else begin
      nc = {1'b0, grid_cols_r};
    end
  end

  assign last_row = (r_r == ROW_W'(nr - DIM_W'(1)));
  assign last_col = (c_r == COL_W'(nc - DIM_W'(1)));
  assign cur_idx  = cell_idx(r_r, c_r);
  assign up_idx   = cell_idx(r_r - ROW_W'(1), c_r);
  assign down_idx = cell_idx(r_r + ROW_W'(1), c_r);
  assign req_idx  = cell_idx(ROW_W'(row_r), COL_W'(col_r));

  assign nb_rr  = {1'b0, row_r} + {6'd0, dr_r};
  assign nb_cc  = {1'b0, col_r} + {6'd0, dc_r};
  assign nb_ok  = (nb_rr != 8'd0) && (nb_cc != 8'd0) &&
                  ({1'b0, nb_rr - 8'd1} < nr) && ({1'b0, nb_cc - 8'd1} < nc);
  assign nb_idx = cell_idx(ROW_W'(nb_rr - 8'd1), COL_W'(nb_cc - 8'd1));

  assign work_a_addr = (cmd == DP_FW_ISSUE) ? up_idx : cur_idx;
  assign heat_addr   = (cmd == DP_NB_ISSUE) ? nb_idx : req_idx;

  assign hit  = ((target_code_r == CODE_OWN) || (target_code_r == CODE_OPP)) &&
                (code_q == target_code_r);
  assign d0   = hit ? dist_t'(0) : FAR_AWAY;
  assign d1   = (r_r != '0) ? min_plus_one(d0, work_a_q) : d0;
  assign fw_d = (c_r != '0) ? min_plus_one(d1, link_r) : d1;
  assign b1   = !last_row ? min_plus_one(work_a_q, work_b_q) : work_a_q;
  assign bw_d = !last_col ? min_plus_one(b1, link_r) : b1;

  always_comb begin
    if (code_q == CODE_OWN) begin
      heat_new = HEAT_OWN;
    end else if (code_q == CODE_OPP) begin
      heat_new = HEAT_OPP;
    end else if (!any_r) begin
      heat_new = '0;
    end else if (16'(bw_d) > 16'(HEAT_CAP)) begin
      heat_new = HEAT_W'(HEAT_CAP);
    end else begin
      heat_new = HEAT_W'(bw_d);
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd == DP_LOAD) begin
      code_mem[req_idx] <= (code_r == CODE_BAD) ? CODE_EMPTY : code_r;
    end
    code_q <= code_mem[cur_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd == DP_FW_USE) begin
      work_mem[cur_idx] <= fw_d;
    end else if (cmd == DP_BW_USE) begin
      work_mem[cur_idx] <= bw_d;
    end
    work_a_q <= work_mem[work_a_addr];
    work_b_q <= work_mem[down_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd == DP_BW_USE) begin
      heat_mem[cur_idx] <= heat_new;
    end
    heat_q <= heat_mem[heat_addr];
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r   <= 8'd128;
      grid_cols_r   <= 8'd128;
      target_code_r <= CODE_OPP;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_ROWS:   grid_rows_r   <= cfg_data;
        CFG_GRID_COLS:   grid_cols_r   <= cfg_data;
        CFG_TARGET_CODE: target_code_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // request, counters and working registers
  always_ff @(posedge clk) begin
    case (cmd)
      DP_LATCH: begin
        req_r     <= req_t'(in_req_type);
        row_r     <= in_row;
        col_r     <= in_col;
        code_r    <= in_cell_code;
        in_grid_r <= ({2'b0, in_row} < nr) && ({2'b0, in_col} < nc);
        res_r     <= '0;
      end
      DP_RD_USE: res_r <= heat_q;
      DP_NB_START: begin
        dr_r  <= 2'd0;
        dc_r  <= 2'd0;
        res_r <= HEAT_NONE;
      end
      DP_NB_ISSUE: nb_ok_r <= nb_ok;
      DP_NB_USE: begin
        if (nb_ok_r && heat_q > 0 && (res_r < 0 || heat_q < res_r)) begin
          res_r <= heat_q;
        end
        if (dc_r == 2'd2) begin
          dc_r <= 2'd0;
          dr_r <= dr_r + 2'd1;
        end else begin
          dc_r <= dc_r + 2'd1;
        end
      end
      DP_FW_START: begin
        r_r   <= '0;
        c_r   <= '0;
        any_r <= 1'b0;
      end
      DP_FW_USE: begin
        link_r <= fw_d;
        any_r  <= any_r | hit;
        // the backward sweep starts where the forward sweep stops
        if (!last_col) begin
          c_r <= c_r + COL_W'(1);
        end else if (!last_row) begin
          c_r <= '0;
          r_r <= r_r + ROW_W'(1);
        end
      end
      DP_BW_USE: begin
        link_r <= bw_d;
        if (c_r == '0) begin
          c_r <= COL_W'(nc - DIM_W'(1));
          r_r <= r_r - ROW_W'(1);
        end else begin
          c_r <= c_r - COL_W'(1);
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd == DP_RESP) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == DP_RESP) begin
      out_value_r  <= res_r;
      out_status_r <= !in_grid_r && (req_r != REQ_BUILD);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  assign status.req      = req_r;
  assign status.in_grid  = in_grid_r;
  assign status.fw_last  = last_row && last_col;
  assign status.bw_last  = (r_r == '0) && (c_r == '0);
  assign status.nb_last  = (dr_r == 2'd2) && (dc_r == 2'd2);
  assign status.out_free = !out_valid_r || out_ready;

endmodule

/* sv/mdh_ctrl.sv */
// controller state machine: sequences loads, reads, neighbor scans and builds
// depends on mdh_pkg
module mdh_ctrl
  import mdh_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (status.req == REQ_BUILD) begin
          state_nxt = ST_FW_ISSUE;
        end else if (!status.in_grid) begin
          state_nxt = ST_RESP;
        end else if (status.req == REQ_LOAD) begin
          state_nxt = ST_LOAD;
        end else if (status.req == REQ_READ) begin
          state_nxt = ST_RD_ISSUE;
        end else begin
          state_nxt = ST_NB_ISSUE;
        end
      end
      ST_LOAD:     state_nxt = ST_RESP;
      ST_RD_ISSUE: state_nxt = ST_RD_USE;
      ST_RD_USE:   state_nxt = ST_RESP;
      ST_NB_ISSUE: state_nxt = ST_NB_USE;
      ST_NB_USE:   state_nxt = status.nb_last ? ST_RESP : ST_NB_ISSUE;
      ST_FW_ISSUE: state_nxt = ST_FW_USE;
      ST_FW_USE:   state_nxt = status.fw_last ? ST_BW_ISSUE : ST_FW_ISSUE;
      ST_BW_ISSUE: state_nxt = ST_BW_USE;
      ST_BW_USE:   state_nxt = status.bw_last ? ST_RESP : ST_BW_ISSUE;
      ST_RESP: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = DP_NOP;
    case (state_r)
      ST_IDLE: begin
        in_ready = rst_n;
        if (rst_n && in_valid) cmd = DP_LATCH;
      end
      ST_DISPATCH: begin
        if (status.req == REQ_BUILD) begin
          cmd = DP_FW_START;
        end else if (status.in_grid && status.req == REQ_NB) begin
          cmd = DP_NB_START;
        end
      end
      ST_LOAD:     cmd = DP_LOAD;
      ST_RD_USE:   cmd = DP_RD_USE;
      ST_NB_ISSUE: cmd = DP_NB_ISSUE;
      ST_NB_USE:   cmd = DP_NB_USE;
      ST_FW_ISSUE: cmd = DP_FW_ISSUE;
      ST_FW_USE:   cmd = DP_FW_USE;
      ST_BW_USE:   cmd = DP_BW_USE;
      ST_RESP: begin
        if (status.out_free) cmd = DP_RESP;
      end
      default: cmd = DP_NOP;
    endcase
  end

endmodule

/* sv/manhattan_distance_heat_map.sv */
// Manhattan distance heat map. Requests arrive one beat at a time: a load writes
// one cell code, a read returns one heat value, a neighbor request scans the 3x3
// window through the single heat memory read port, and a build runs a forward and
// a backward raster sweep of the configured grid, visiting each cell in an issue
// state and then a use state, as the distance work memory has a registered read.
// A new request is taken once the previous one has placed its result in the
// output register.
// depends on mdh_pkg, mdh_in_if, mdh_out_if, mdh_ctrl, mdh_datapath
module manhattan_distance_heat_map
  import mdh_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  mdh_in_if.sink    in_ch,
  mdh_out_if.source out_ch,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  mdh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  mdh_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_req_type  (in_ch.req_type),
    .in_row       (in_ch.row),
    .in_col       (in_ch.col),
    .in_cell_code (in_ch.cell_code),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_value    (out_ch.value),
    .out_status   (out_ch.status)
  );

endmodule

/* tb/tb.sv */
// self-checking bench for the manhattan distance heat map: grid loads, builds, reads and
// neighbor queries checked against an in-bench prediction through a small scoreboard class
// depends on mdh_pkg, mdh_in_if, mdh_out_if and manhattan_distance_heat_map
module tb
  import mdh_pkg::*;
();

  localparam int HOLD_LONG  = 300;
  localparam int STUCK_LIMIT = 20000;

  class heat_scoreboard;
    typedef struct {
      heat_t value;
      logic  status;
    } heat_result_t;

    logic [1:0]   codes[CELLS];
    heat_t        heat_vals[CELLS];
    logic [7:0]   rows_reg;
    logic [7:0]   cols_reg;
    logic [1:0]   target_reg;
    heat_result_t awaited[$];
    int           errors;

    function new();
      foreach (codes[i]) codes[i] = CODE_EMPTY;
      foreach (heat_vals[i]) heat_vals[i] = '0;
      rows_reg = 8'd128;
      cols_reg = 8'd128;
      target_reg = CODE_OPP;
      errors = 0;
    endfunction

    function int clip(logic [7:0] v);
      if (v == 0) return 1;
      return (v > MAX_ROWS) ? MAX_ROWS : int'(v);
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] data);
      case (idx)
        CFG_GRID_ROWS: rows_reg = data;
        CFG_GRID_COLS: cols_reg = data;
        CFG_TARGET_CODE: target_reg = data[1:0];
        default: ;
      endcase
    endfunction

    function void build_heat();
      int nr, nc, best, d;
      int tr[$];
      int tc[$];
      nr = clip(rows_reg);
      nc = clip(cols_reg);
      for (int r = 0; r < nr; r++)
        for (int c = 0; c < nc; c++)
          if ((target_reg == CODE_OWN || target_reg == CODE_OPP) &&
              codes[r * MAX_COLS + c] == target_reg) begin
            tr.push_back(r);
            tc.push_back(c);
          end
      for (int r = 0; r < nr; r++)
        for (int c = 0; c < nc; c++) begin
          if (codes[r * MAX_COLS + c] == CODE_OWN) begin
            heat_vals[r * MAX_COLS + c] = HEAT_OWN;
          end else if (codes[r * MAX_COLS + c] == CODE_OPP) begin
            heat_vals[r * MAX_COLS + c] = HEAT_OPP;
          end else if (tr.size() == 0) begin
            heat_vals[r * MAX_COLS + c] = '0;
          end else begin
            best = 1 << 20;
            foreach (tr[k]) begin
              d = ((r > tr[k]) ? r - tr[k] : tr[k] - r) + ((c > tc[k]) ? c - tc[k] : tc[k] - c);
              if (d < best) best = d;
            end
            if (best > HEAT_CAP) best = HEAT_CAP;
            heat_vals[r * MAX_COLS + c] = heat_t'(best);
          end
        end
    endfunction

    function heat_t window_min(int row, int col);
      int nr, nc;
      heat_t best, h;
      nr = clip(rows_reg);
      nc = clip(cols_reg);
      best = HEAT_NONE;
      for (int r = (row > 0 ? row - 1 : 0); r <= row + 1 && r < nr; r++)
        for (int c = (col > 0 ? col - 1 : 0); c <= col + 1 && c < nc; c++) begin
          h = heat_vals[r * MAX_COLS + c];
          if (h > 0 && (best < 0 || h < best)) best = h;
        end
      return best;
    endfunction

    function void note_request(logic [1:0] req, logic [6:0] row, logic [6:0] col,
                               logic [1:0] code);
      heat_result_t res;
      res.value = '0;
      res.status = 1'b0;
      if (req_t'(req) == REQ_BUILD) begin
        build_heat();
      end else if (!(row < clip(rows_reg) && col < clip(cols_reg))) begin
        res.status = 1'b1;
      end else begin
        case (req_t'(req))
          REQ_LOAD: codes[row * MAX_COLS + col] = (code == CODE_BAD) ? CODE_EMPTY : code;
          REQ_READ: res.value = heat_vals[row * MAX_COLS + col];
          default: res.value = window_min(row, col);
        endcase
      end
      awaited.push_back(res);
    endfunction

    function void check_result(heat_t value, logic status);
      heat_result_t res;
      if (awaited.size() == 0) begin
        $error("result beat with nothing awaited: value %0d status %0d", value, status);
        errors++;
        return;
      end
      res = awaited.pop_front();
      if (value !== res.value) begin
        $error("value: expected %0d, got %0d", res.value, value);
        errors++;
      end
      if (status !== res.status) begin
        $error("status: expected %0d, got %0d", res.status, status);
        errors++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  logic in_took;
  bit quiet;
  bit long_hold;
  int stuck_cycles;
  heat_scoreboard sb;

  mdh_in_if  in_if ();
  mdh_out_if out_if ();

  manhattan_distance_heat_map u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    in_took <= in_if.valid && in_if.ready;
    if (rst_n && in_if.valid && in_if.ready)
      sb.note_request(in_if.req_type, in_if.row, in_if.col, in_if.cell_code);
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result(out_if.value, out_if.status);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : result_ready
    bit served;
    served = 0;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold && !served && in_if.valid) begin
        served = 1;
        out_if.ready = 1'b0;
        repeat (HOLD_LONG) @(negedge clk);
      end else if (!quiet && $urandom_range(5) == 0) begin
        out_if.ready = 1'b0;
        repeat ($urandom_range(11, 1)) @(negedge clk);
      end
      out_if.ready = 1'b1;
    end
  end

  task automatic send(req_t rq, logic [6:0] row, logic [6:0] col, logic [1:0] code);
    if (!quiet && $urandom_range(3) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(11, 1)) @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.req_type = rq;
    in_if.row = row;
    in_if.col = col;
    in_if.cell_code = code;
    do @(negedge clk); while (!in_took);
  endtask

  task automatic wait_drained();
    in_if.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_grid();
    for (int r = 0; r < sb.clip(sb.rows_reg); r++)
      for (int c = 0; c < sb.clip(sb.cols_reg); c++)
        send(REQ_LOAD, r[6:0], c[6:0],
             ($urandom_range(3) == 0) ? sb.target_reg : 2'($urandom_range(3)));
    send(REQ_BUILD, 7'($urandom), 7'($urandom), 2'($urandom));
  endtask

  task automatic run_phase(logic [7:0] rows, logic [7:0] cols, logic [1:0] tgt, int count);
    int nr, nc, pick;
    logic [6:0] r;
    logic [6:0] c;
    wait_drained();
    write_reg(CFG_GRID_ROWS, rows);
    write_reg(CFG_GRID_COLS, cols);
    write_reg(CFG_TARGET_CODE, tgt);
    nr = sb.clip(rows);
    nc = sb.clip(cols);
    load_grid();
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(4) == 0) begin
        r = 7'($urandom);
        c = 7'($urandom);
      end else begin
        r = 7'($urandom_range(nr - 1));
        c = 7'($urandom_range(nc - 1));
      end
      pick = $urandom_range(9);
      if (pick < 3) send(REQ_LOAD, r, c, 2'($urandom));
      else if (pick < 4) send(REQ_BUILD, r, c, 2'($urandom));
      else if (pick < 7) send(REQ_READ, r, c, 2'($urandom));
      else send(REQ_NB, r, c, 2'($urandom));
    end
  endtask

  initial begin
    sb = new();
    quiet = 0;
    long_hold = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_GRID_ROWS;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.req_type = REQ_LOAD;
    in_if.row = '0;
    in_if.col = '0;
    in_if.cell_code = CODE_EMPTY;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: small grid, corners, out-of-grid and code three
    write_reg(CFG_GRID_ROWS, 8'd2);
    write_reg(CFG_GRID_COLS, 8'd3);
    write_reg(CFG_TARGET_CODE, CODE_OPP);
    send(REQ_LOAD, 7'd0, 7'd0, CODE_OPP);
    send(REQ_LOAD, 7'd0, 7'd1, CODE_EMPTY);
    send(REQ_LOAD, 7'd0, 7'd2, CODE_BAD);
    send(REQ_LOAD, 7'd1, 7'd0, CODE_OWN);
    send(REQ_LOAD, 7'd1, 7'd1, CODE_EMPTY);
    send(REQ_LOAD, 7'd1, 7'd2, CODE_EMPTY);
    send(REQ_LOAD, 7'd127, 7'd127, CODE_OWN);
    send(REQ_LOAD, 7'd2, 7'd0, CODE_OPP);
    send(REQ_BUILD, 7'd127, 7'd127, CODE_BAD);
    send(REQ_READ, 7'd0, 7'd0, CODE_EMPTY);
    send(REQ_READ, 7'd1, 7'd0, CODE_EMPTY);
    send(REQ_READ, 7'd1, 7'd2, CODE_EMPTY);
    send(REQ_READ, 7'd0, 7'd3, CODE_EMPTY);
    send(REQ_NB, 7'd0, 7'd0, CODE_EMPTY);
    send(REQ_NB, 7'd1, 7'd2, CODE_EMPTY);
    send(REQ_NB, 7'd127, 7'd0, CODE_EMPTY);
    send(REQ_LOAD, 7'd0, 7'd1, CODE_OWN);
    send(REQ_LOAD, 7'd1, 7'd1, CODE_OWN);
    send(REQ_LOAD, 7'd1, 7'd2, CODE_OWN);
    send(REQ_BUILD, 7'd0, 7'd0, CODE_EMPTY);
    send(REQ_NB, 7'd0, 7'd1, CODE_EMPTY);
    send(REQ_READ, 7'd0, 7'd2, CODE_EMPTY);

    run_phase(8'd1, 8'd1, CODE_OWN, 80);
    run_phase(8'd128, 8'd1, CODE_OPP, 200);
    run_phase(8'd0, 8'd255, CODE_OWN, 200);
    long_hold = 1;
    run_phase(8'd8, 8'd8, CODE_OPP, 150);
    run_phase(8'd200, 8'd1, 2'd3, 120);
    run_phase(8'd5, 8'd7, 2'd0, 120);
    run_phase(8'd11, 8'd12, CODE_OWN, 150);
    quiet = 1;
    run_phase(8'd3, 8'd4, CODE_OPP, 180);

    wait_drained();
    repeat (20) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
